// ----- rtl/pbrf_pkg.sv -----
package pbrf_pkg;

  localparam int ADDR_W = 32;
  localparam int HALF_W = 16;
  localparam int ENTRY_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NEW_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OLD_BASE = 2'd1;

  localparam logic [3:0] RT_ABSOLUTE = 4'd0;
  localparam logic [3:0] RT_HIGH     = 4'd1;
  localparam logic [3:0] RT_LOW      = 4'd2;
  localparam logic [3:0] RT_HIGHLOW  = 4'd3;
  localparam logic [3:0] RT_HIGHADJ  = 4'd4;
  localparam logic [3:0] RT_SECTION  = 4'd6;
  localparam logic [3:0] RT_REL32    = 4'd7;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_ENTRY  = 1'b1;

  localparam logic [ADDR_W-1:0] ROUND_HALF = 32'h0000_8000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_WAIT    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // What the back end has to do with one request.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_WIDE = 2'd1,
    CMD_HIGH = 2'd2,
    CMD_LOW  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] operand;
    status_t           status;
  } cmd_t;

endpackage

// ----- rtl/pbrf_if.sv -----
interface pbrf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] page_offset;
  logic [15:0] entry;
  logic [31:0] target_value;

  modport source (output valid, output operation, output page_offset, output entry,
                  output target_value, input ready);
  modport sink (input valid, input operation, input page_offset, input entry,
                input target_value, output ready);
endinterface

interface pbrf_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] write_address;
  logic [31:0] write_value;
  logic        write_wide;
  logic [1:0]  status;

  modport source (output valid, output write_enable, output write_address,
                  output write_value, output write_wide, output status, input ready);
  modport sink (input valid, input write_enable, input write_address,
                input write_value, input write_wide, input status, output ready);
endinterface

// ----- rtl/pbrf_front.sv -----
module pbrf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  pbrf_in_if.sink                in_ch,
  input  logic [31:0]            new_base,
  input  logic                   q_ready,
  output logic                   q_push,
  output pbrf_pkg::cmd_t         q_cmd
);
  import pbrf_pkg::*;

  logic [ADDR_W-1:0] page_r, page_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [HALF_W-1:0] pend_high_r, pend_high_nxt;
  logic              inv_r, inv_nxt;

  logic              accept;
  logic [3:0]        rtype;
  logic [ADDR_W-1:0] entry_addr;
  logic [HALF_W-1:0] t16;
  logic [ADDR_W-1:0] low_sext;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid & q_ready;
  assign q_push      = accept;

  assign rtype      = in_ch.entry[ENTRY_W-1 -: 4];
  assign entry_addr = page_r + {20'd0, in_ch.entry[11:0]};
  assign t16        = in_ch.target_value[HALF_W-1:0];
  assign low_sext   = {{HALF_W{in_ch.entry[ENTRY_W-1]}}, in_ch.entry};

  always_comb begin
    page_nxt      = page_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    pend_high_nxt = pend_high_r;
    inv_nxt       = inv_r;
    q_cmd.kind    = CMD_NONE;
    q_cmd.address = '0;
    q_cmd.operand = '0;

    if (in_ch.operation == OP_HEADER) begin
      if (pend_r) begin
        inv_nxt = 1'b1;
      end
      pend_nxt = 1'b0;
      page_nxt = new_base + in_ch.page_offset;
    end else if (inv_r) begin
      pend_nxt = 1'b0;
    end else if (pend_r) begin
      // The entry after a HIGHADJ is the signed low half; rounding is folded in here
      // so the back end only has to add the delta.
      q_cmd.kind    = CMD_HIGH;
      q_cmd.address = pend_addr_r;
      q_cmd.operand = {pend_high_r, {HALF_W{1'b0}}} + low_sext + ROUND_HALF;
      pend_nxt      = 1'b0;
    end else begin
      unique case (rtype)
        RT_HIGHLOW: begin
          q_cmd.kind    = CMD_WIDE;
          q_cmd.address = entry_addr;
          q_cmd.operand = in_ch.target_value;
        end
        RT_HIGH: begin
          q_cmd.kind    = CMD_HIGH;
          q_cmd.address = entry_addr;
          q_cmd.operand = {t16, {HALF_W{1'b0}}};
        end
        RT_LOW: begin
          q_cmd.kind    = CMD_LOW;
          q_cmd.address = entry_addr;
          q_cmd.operand = {{HALF_W{1'b0}}, t16};
        end
        RT_HIGHADJ: begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = entry_addr;
          pend_high_nxt = t16;
        end
        RT_ABSOLUTE, RT_SECTION, RT_REL32: begin
          pend_nxt = 1'b0;
        end
        default: begin
          inv_nxt = 1'b1;
        end
      endcase
    end

    if (inv_nxt) begin
      q_cmd.status = ST_INVALID;
    end else if (pend_nxt) begin
      q_cmd.status = ST_WAIT;
    end else begin
      q_cmd.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r      <= '0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
      pend_high_r <= '0;
      inv_r       <= 1'b0;
    end else if (accept) begin
      page_r      <= page_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_high_r <= pend_high_nxt;
      inv_r       <= inv_nxt;
    end
  end

  a_invalid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    inv_r |=> inv_r)
    else $error("invalid status was cleared without reset");

endmodule

// ----- rtl/pbrf_queue.sv -----
module pbrf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pbrf_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output pbrf_pkg::cmd_t  pop_cmd
);
  import pbrf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(QUEUE_DEPTH)) && !pop |=> count_r == CNT_W'(QUEUE_DEPTH))
    else $error("queue lost an entry while full");

endmodule

// ----- rtl/pbrf_back.sv -----
module pbrf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     new_base,
  input  logic [31:0]     old_base,
  input  logic            q_valid,
  input  pbrf_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  pbrf_out_if.source      out_ch
);
  import pbrf_pkg::*;

  logic [ADDR_W-1:0] delta_r;
  logic [ADDR_W-1:0] sum;
  logic              load;
  logic              out_valid_r;
  logic              we_r, we_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] value_r, value_nxt;
  logic              wide_r, wide_nxt;
  status_t           status_r;

  assign load  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = load;
  assign sum   = q_cmd.operand + delta_r;

  always_comb begin
    we_nxt    = 1'b1;
    addr_nxt  = q_cmd.address;
    value_nxt = '0;
    wide_nxt  = 1'b0;
    unique case (q_cmd.kind)
      CMD_NONE: begin
        we_nxt   = 1'b0;
        addr_nxt = '0;
      end
      CMD_WIDE: begin
        value_nxt = sum;
        wide_nxt  = 1'b1;
      end
      CMD_HIGH: value_nxt = {{HALF_W{1'b0}}, sum[ADDR_W-1 -: HALF_W]};
      CMD_LOW:  value_nxt = {{HALF_W{1'b0}}, sum[HALF_W-1:0]};
    endcase
  end

  // The user must change configuration only while the block is idle (not enforced); delta_r's lag is then harmless.
  always_ff @(posedge clk) begin
    delta_r <= new_base - old_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      we_r     <= we_nxt;
      addr_r   <= addr_nxt;
      value_r  <= value_nxt;
      wide_r   <= wide_nxt;
      status_r <= q_cmd.status;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_enable  = we_r;
  assign out_ch.write_address = addr_r;
  assign out_ch.write_value   = value_r;
  assign out_ch.write_wide    = wide_r;
  assign out_ch.status        = status_r;

  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !we_r |-> addr_r == '0 && value_r == '0 && !wide_r)
    else $error("request without a write carries a payload");

  a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && we_r && !wide_r |-> value_r[ADDR_W-1:HALF_W] == '0)
    else $error("halfword write has upper bits set");

endmodule

// ----- rtl/pe_base_relocation_fixup.sv -----
// PE base relocation fixup engine.
// The input channel in_ch takes one request per cycle while in_ch.ready is
// high: a block header (operation 0, page_offset) or a relocation entry
// (operation 1, entry and the current memory contents at the target in
// target_value). Every request yields exactly one result on out_ch: an
// optional write (address, value, width) and the status code (ok, waiting
// for a HIGHADJ low half, invalid). new_base and old_base must be set
// through the cfg_ write port only while idle; the block does not enforce
// this. The front end classifies and tracks page and HIGHADJ state, and the
// back end adds the relocation delta in one adder. A two-entry queue sits
// between them, so input is accepted as long as the queue has room even
// while a result waits on a stalled receiver; once the queue and output
// register are full, in_ch.ready drops. Reset clears both base registers,
// the page address, the pending HIGHADJ and the sticky invalid flag; no
// clearing pass is needed.
module pe_base_relocation_fixup (
  input  logic                                clk,
  input  logic                                rst_n,
  pbrf_in_if.sink                             in_ch,
  pbrf_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pbrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);
  import pbrf_pkg::*;

  logic [ADDR_W-1:0] new_base_r;
  logic [ADDR_W-1:0] old_base_r;

  logic q_push, q_ready, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_base_r <= '0;
      old_base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NEW_BASE) begin
        new_base_r <= cfg_data;
      end
      if (cfg_index == CFG_OLD_BASE) begin
        old_base_r <= cfg_data;
      end
    end
  end

  pbrf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .new_base (new_base_r),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  pbrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  pbrf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .new_base (new_base_r),
    .old_base (old_base_r),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
